### hw/rtl/bounded_ordered_list_unit_macros.svh
// Assertion macros shared by the bounded ordered list checker
`ifndef BOUNDED_ORDERED_LIST_UNIT_MACROS_SVH
`define BOUNDED_ORDERED_LIST_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BOLU_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bolu check failed");

// Next-cycle implication, disabled while reset is asserted
`define BOLU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bolu check failed");

`endif

### hw/rtl/bolu_pkg.sv
// Types and codes for the bounded ordered list unit
`default_nettype none

package bolu_pkg;

	localparam int KIND_BITS   = 3;
	localparam int POS_BITS    = 5;
	localparam int STATUS_BITS = 2;

	// request kinds
	localparam logic [KIND_BITS-1:0] KIND_INS_FRONT  = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_INS_REAR   = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_INS_AT     = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_INS_SORTED = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_DEL_FRONT  = 3'd4;
	localparam logic [KIND_BITS-1:0] KIND_DEL_REAR   = 3'd5;
	localparam logic [KIND_BITS-1:0] KIND_DEL_AT     = 3'd6;
	localparam logic [KIND_BITS-1:0] KIND_READ_AT    = 3'd7;

	// result status codes
	localparam logic [STATUS_BITS-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_FULL   = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_EMPTY  = 2'd2;
	localparam logic [STATUS_BITS-1:0] STAT_BADPOS = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT_UP,
		S_DEL,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/bounded_ordered_list_unit.sv
// Steps: an error goes straight to the result beat; a read fetches the one entry; a
//   delete moves the later entries down; an insert moves the entries from the position
//   up, none at the rear, then writes the new one; a sorted insert first seeks the
//   first key not smaller, else takes the rear. Throughput: one request at a time, the
//   next taken as the result beat shows; one entry moves per cycle. Reset: arst_n clears
//   count and control; the store is not cleared, since only held entries are read.
`default_nettype none

module bounded_ordered_list_unit #(
	parameter int CAPACITY  = 32,
	parameter int KEY_BITS  = 8,
	parameter int DATA_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire logic [bolu_pkg::KIND_BITS-1:0]      kind,
	input  wire logic [KEY_BITS-1:0]                 entry_key,
	input  wire logic [DATA_BITS-1:0]                entry_data,
	input  wire logic [bolu_pkg::POS_BITS-1:0]       position,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output logic [bolu_pkg::STATUS_BITS-1:0]         status,
	output logic [$clog2(CAPACITY+1)-1:0]            entry_count,
	output logic                                     out_valid,
	output logic [KEY_BITS-1:0]                      out_key,
	output logic [DATA_BITS-1:0]                     out_data
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam int ENT_W = KEY_BITS + DATA_BITS;
	localparam int CMP_W = (CNT_W > bolu_pkg::POS_BITS) ? CNT_W : bolu_pkg::POS_BITS;

	// entry store: key in the upper bits, payload below
	logic [ENT_W-1:0] mem [CAPACITY];

	bolu_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] j_q, j_d;
	logic [CNT_W-1:0] at_q, at_d;
	logic [CNT_W-1:0] lim_q, lim_d;

	logic [bolu_pkg::KIND_BITS-1:0]   kind_q;
	logic [KEY_BITS-1:0]              key_q;
	logic [DATA_BITS-1:0]             data_q;
	logic [bolu_pkg::STATUS_BITS-1:0] wst_q, acc_status;
	logic                             wval_q;
	logic [KEY_BITS-1:0]              wkey_q;
	logic [DATA_BITS-1:0]             wdat_q;

	// read stage
	logic             wr_s1, cap_s1, chk_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ENT_W-1:0] rd_data_s1;

	logic             issue_wr, issue_cap, issue_chk;
	logic [IDX_W-1:0] issue_idx, rd_addr;
	logic             new_we, take_in, load_out, found;
	logic [CMP_W-1:0] pos_cmp, cnt_cmp;
	logic [CNT_W-1:0] del_at;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [ENT_W-1:0] mem_wd;

	logic                             rsp_valid_q;
	logic [bolu_pkg::STATUS_BITS-1:0] status_q;
	logic [CNT_W-1:0]                 count_out_q;
	logic                             oval_q;
	logic [KEY_BITS-1:0]              okey_q;
	logic [DATA_BITS-1:0]             odat_q;

	assign pos_cmp = CMP_W'(position);
	assign cnt_cmp = CMP_W'(count_q);
	assign found   = chk_s1 && !(rd_data_s1[ENT_W-1 -: KEY_BITS] < key_q);
	assign take_in = req_valid && (state_q == bolu_pkg::S_IDLE);

	// pick the removal index for delete and read requests
	always_comb begin
		if (kind == bolu_pkg::KIND_DEL_FRONT) begin
			del_at = '0;
		end else if (kind == bolu_pkg::KIND_DEL_REAR) begin
			del_at = count_q - CNT_W'(1);
		end else begin
			del_at = CNT_W'(position);
		end
	end

	// next state and sequencing of the store accesses
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		j_d        = j_q;
		at_d       = at_q;
		lim_d      = lim_q;
		acc_status = bolu_pkg::STAT_OK;
		rd_addr    = '0;
		issue_wr   = 1'b0;
		issue_cap  = 1'b0;
		issue_chk  = 1'b0;
		issue_idx  = '0;
		new_we     = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			bolu_pkg::S_IDLE: begin
				if (req_valid) begin
					if (kind <= bolu_pkg::KIND_INS_SORTED) begin
						if (count_q == CNT_W'(CAPACITY)) begin
							acc_status = bolu_pkg::STAT_FULL;
							state_d    = bolu_pkg::S_DONE;
						end else if (kind == bolu_pkg::KIND_INS_SORTED) begin
							j_d     = '0;
							state_d = bolu_pkg::S_SEARCH;
						end else if (kind == bolu_pkg::KIND_INS_AT && pos_cmp > cnt_cmp) begin
							acc_status = bolu_pkg::STAT_BADPOS;
							state_d    = bolu_pkg::S_DONE;
						end else begin
							if (kind == bolu_pkg::KIND_INS_FRONT) begin
								at_d = '0;
							end else if (kind == bolu_pkg::KIND_INS_REAR) begin
								at_d = count_q;
							end else begin
								at_d = CNT_W'(position);
							end
							j_d     = count_q;
							state_d = bolu_pkg::S_SHIFT_UP;
						end
					end else begin
						if (count_q == '0) begin
							acc_status = bolu_pkg::STAT_EMPTY;
							state_d    = bolu_pkg::S_DONE;
						end else if ((kind == bolu_pkg::KIND_DEL_AT ||
						              kind == bolu_pkg::KIND_READ_AT) && pos_cmp >= cnt_cmp) begin
							acc_status = bolu_pkg::STAT_BADPOS;
							state_d    = bolu_pkg::S_DONE;
						end else begin
							at_d    = del_at;
							j_d     = del_at;
							lim_d   = (kind == bolu_pkg::KIND_READ_AT) ?
							          del_at + CNT_W'(1) : count_q;
							state_d = bolu_pkg::S_DEL;
						end
					end
				end
			end
			bolu_pkg::S_SEARCH: begin
				if (found) begin
					at_d    = CNT_W'(idx_s1);
					j_d     = count_q;
					state_d = bolu_pkg::S_SHIFT_UP;
				end else if (j_q < count_q) begin
					rd_addr   = IDX_W'(j_q);
					issue_chk = 1'b1;
					issue_idx = IDX_W'(j_q);
					j_d       = j_q + CNT_W'(1);
				end else if (!chk_s1) begin
					at_d    = count_q;
					j_d     = count_q;
					state_d = bolu_pkg::S_SHIFT_UP;
				end
			end
			bolu_pkg::S_SHIFT_UP: begin
				if (j_q > at_q) begin
					rd_addr   = IDX_W'(j_q - CNT_W'(1));
					issue_wr  = 1'b1;
					issue_idx = IDX_W'(j_q);
					j_d       = j_q - CNT_W'(1);
				end else if (!wr_s1) begin
					new_we  = 1'b1;
					count_d = count_q + CNT_W'(1);
					state_d = bolu_pkg::S_DONE;
				end
			end
			bolu_pkg::S_DEL: begin
				if (j_q < lim_q) begin
					rd_addr   = IDX_W'(j_q);
					issue_wr  = (j_q != at_q);
					issue_cap = (j_q == at_q);
					issue_idx = IDX_W'(j_q - CNT_W'(1));
					j_d       = j_q + CNT_W'(1);
				end else if (!wr_s1 && !cap_s1) begin
					if (kind_q != bolu_pkg::KIND_READ_AT) begin
						count_d = count_q - CNT_W'(1);
					end
					state_d = bolu_pkg::S_DONE;
				end
			end
			bolu_pkg::S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_out = 1'b1;
					state_d  = bolu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bolu_pkg::S_IDLE;
			end
		endcase
	end

	// write port: a shifted entry takes priority over the new entry
	assign mem_we = wr_s1 || new_we;
	assign mem_wa = wr_s1 ? idx_s1 : IDX_W'(at_q);
	assign mem_wd = wr_s1 ? rd_data_s1 : {key_q, data_q};

	// store write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bolu_pkg::S_IDLE;
			count_q     <= '0;
			j_q         <= '0;
			at_q        <= '0;
			lim_q       <= '0;
			wr_s1       <= 1'b0;
			cap_s1      <= 1'b0;
			chk_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			j_q     <= j_d;
			at_q    <= at_d;
			lim_q   <= lim_d;
			wr_s1   <= issue_wr;
			cap_s1  <= issue_cap;
			chk_s1  <= issue_chk;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request fields and working result
	always_ff @(posedge clk) begin
		idx_s1 <= issue_idx;
		if (take_in) begin
			kind_q <= kind;
			key_q  <= entry_key;
			data_q <= entry_data;
			wst_q  <= acc_status;
			wval_q <= 1'b0;
			wkey_q <= '0;
			wdat_q <= '0;
		end else if (cap_s1) begin
			wval_q <= 1'b1;
			wkey_q <= rd_data_s1[ENT_W-1 -: KEY_BITS];
			wdat_q <= rd_data_s1[DATA_BITS-1:0];
		end
	end

	// hold the result beat until it is taken
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q    <= wst_q;
			count_out_q <= count_q;
			oval_q      <= wval_q;
			okey_q      <= wkey_q;
			odat_q      <= wdat_q;
		end
	end

	assign req_stall   = (state_q != bolu_pkg::S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_count = count_out_q;
	assign out_valid   = oval_q;
	assign out_key     = okey_q;
	assign out_data    = odat_q;

endmodule

`default_nettype wire

### hw/rtl/bolu_checker.sv
// Port-level checks for the bounded ordered list unit, bound to its top level
`default_nettype none
`include "bounded_ordered_list_unit_macros.svh"

module bolu_checker #(
	parameter int CAPACITY  = 32,
	parameter int KEY_BITS  = 8,
	parameter int DATA_BITS = 32
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                rsp_valid,
	input wire logic                                rsp_stall,
	input wire logic [bolu_pkg::STATUS_BITS-1:0]    status,
	input wire logic [$clog2(CAPACITY+1)-1:0]       entry_count,
	input wire logic                                out_valid,
	input wire logic [KEY_BITS-1:0]                 out_key,
	input wire logic [DATA_BITS-1:0]                out_data
);

	localparam int CNT_W = $clog2(CAPACITY+1);

	// a stalled result beat holds
	`BOLU_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(entry_count) && $stable(out_valid) && $stable(out_key) && $stable(out_data))

	// only a successful request returns an entry
	`BOLU_ASSERT_NOW(a_entry_ok, clk, arst_n, rsp_valid && out_valid, status == bolu_pkg::STAT_OK)

	// full is reported only at capacity
	`BOLU_ASSERT_NOW(a_full_cnt, clk, arst_n, rsp_valid && status == bolu_pkg::STAT_FULL, entry_count == CNT_W'(CAPACITY))

	// empty is reported only with no entries and no entry returned
	`BOLU_ASSERT_NOW(a_empty_cnt, clk, arst_n, rsp_valid && status == bolu_pkg::STAT_EMPTY, entry_count == '0 && !out_valid)

	// without a returned entry the entry fields are zero
	`BOLU_ASSERT_NOW(a_zero_fields, clk, arst_n, rsp_valid && !out_valid, out_key == '0 && out_data == '0)

endmodule

bind bounded_ordered_list_unit bolu_checker #(
	.CAPACITY  (CAPACITY),
	.KEY_BITS  (KEY_BITS),
	.DATA_BITS (DATA_BITS)
) u_bolu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.status      (status),
	.entry_count (entry_count),
	.out_valid   (out_valid),
	.out_key     (out_key),
	.out_data    (out_data)
);

`default_nettype wire
